// ===== rtl/ptts_pkg.sv =====
// package for the periodic task tick scheduler
// holds table size, field widths, opcode and state encodings, slot entry layout
// no dependencies
`default_nettype none

package ptts_pkg;

    // table size, one slot per task priority
    localparam int NUM_SLOTS    = 8;
    localparam int SLOT_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W        = $clog2(NUM_SLOTS + 1);

    // fixed field widths
    localparam int OPCODE_W     = 3;
    localparam int SLOT_FIELD_W = 3;
    localparam int TIME_W       = 16;
    localparam int MASK_W       = 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK    = 3'd0,
        OP_CREATE  = 3'd1,
        OP_DELETE  = 3'd2,
        OP_SUSPEND = 3'd3,
        OP_RESUME  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_HOLD
    } state_t;

    // one memory word per slot
    typedef struct packed {
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] countdown;
    } entry_t;

endpackage

`default_nettype wire

// ===== rtl/periodic_task_tick_scheduler_top.sv =====
// top level of the periodic task tick scheduler
// slot table memory, per-slot flag flops, tick walk sequencer and output register
// depends on ptts_pkg
`default_nettype none

//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_stall  | opcode, slot, period, first_delay
//  output  | out_valid / out_stall| status, fired_mask
//
//  create, delete, suspend, resume and unused opcodes finish in the cycle the
//  item is accepted; a tick walks the slot memory one slot per cycle through
//  the single read port of the slot memory, whose read data is registered
//  an item is taken while a finished result still waits in the output register;
//  if that result is still stalled when the next one is done, the new result
//  parks in a holding register and the input stalls until it moves on
//  reset clears the valid, suspended and written flags; no memory clearing pass

module periodic_task_tick_scheduler_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [ptts_pkg::OPCODE_W-1:0]     opcode,
    input  wire logic [ptts_pkg::SLOT_FIELD_W-1:0] slot,
    input  wire logic [ptts_pkg::TIME_W-1:0]       period,
    input  wire logic [ptts_pkg::TIME_W-1:0]       first_delay,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   status,
    output logic [ptts_pkg::MASK_W-1:0]            fired_mask
);
    import ptts_pkg::*;

    // slot table: period and countdown per slot, one write and one read port
    entry_t               mem [NUM_SLOTS];
    entry_t               rd_data_reg;
    logic                 mem_we;
    logic [SLOT_W-1:0]    mem_waddr;
    entry_t               mem_wdata;
    logic [SLOT_W-1:0]    mem_raddr;

    // per-slot flags in flops so reset takes effect at once
    // written flag: countdown word holds real data, otherwise it reads as zero
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [NUM_SLOTS-1:0] susp_reg, susp_next;
    logic [NUM_SLOTS-1:0] init_reg, init_next;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [MASK_W-1:0]    mask_reg, mask_next;

    // result waiting for the output register
    logic                 pend_status_reg;
    logic [MASK_W-1:0]    pend_mask_reg;

    logic                 out_valid_reg;
    logic                 status_reg;
    logic [MASK_W-1:0]    fired_mask_reg;

    logic                 in_accept;
    logic                 out_free;
    op_t                  op;
    logic [SLOT_W+SLOT_FIELD_W-1:0] slot_wide;
    logic [SLOT_W-1:0]    slot_idx;
    logic                 in_table;

    // walk stage signals
    logic [CNT_W-1:0]     proc_cnt;
    logic [SLOT_W-1:0]    proc_idx;
    logic                 walk_last;
    logic [TIME_W-1:0]    cur_cd;
    logic [MASK_W-1:0]    fire_bit;

    logic                 res_valid;
    logic                 res_status;
    logic [MASK_W-1:0]    res_mask;
    logic                 out_load;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign op        = op_t'(opcode);

    // slot field mapped onto the table index, out of range slots flagged
    assign slot_wide = {{SLOT_W{1'b0}}, slot};
    assign slot_idx  = slot_wide[SLOT_W-1:0];
    assign in_table  = slot_wide < (SLOT_W + SLOT_FIELD_W)'(NUM_SLOTS);

    // slot whose read data arrives this cycle during a walk
    assign proc_cnt  = CNT_W'(cnt_reg - 1'b1);
    assign proc_idx  = proc_cnt[SLOT_W-1:0];
    assign walk_last = (cnt_reg == CNT_W'(NUM_SLOTS));
    assign cur_cd    = init_reg[proc_idx] ? rd_data_reg.countdown : '0;
    // shifting past the mask width drops slots that cannot be reported
    assign fire_bit  = MASK_W'(1) << proc_idx;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (op == OP_TICK)
                    begin
                        state_next = ST_WALK;
                    end
                    else if (!out_free)
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_WALK:
            begin
                if (walk_last)
                begin
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        mem_we     = 1'b0;
        mem_waddr  = proc_idx;
        mem_wdata  = rd_data_reg;
        mem_raddr  = cnt_reg[SLOT_W-1:0];
        valid_next = valid_reg;
        susp_next  = susp_reg;
        init_next  = init_reg;
        cnt_next   = cnt_reg;
        mask_next  = mask_reg;
        res_valid  = 1'b0;
        res_status = 1'b0;
        res_mask   = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    res_valid = (op != OP_TICK);
                    unique case (op)
                        OP_TICK:
                        begin
                            cnt_next  = '0;
                            mask_next = '0;
                        end
                        OP_CREATE:
                        begin
                            if (!in_table || valid_reg[slot_idx])
                            begin
                                res_status = 1'b1;
                            end
                            else
                            begin
                                mem_we               = 1'b1;
                                mem_waddr            = slot_idx;
                                mem_wdata.period     = period;
                                mem_wdata.countdown  = first_delay;
                                valid_next[slot_idx] = 1'b1;
                                susp_next[slot_idx]  = 1'b0;
                                init_next[slot_idx]  = 1'b1;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (in_table)
                            begin
                                valid_next[slot_idx] = 1'b0;
                            end
                        end
                        OP_SUSPEND:
                        begin
                            if (in_table)
                            begin
                                susp_next[slot_idx] = 1'b1;
                            end
                        end
                        OP_RESUME:
                        begin
                            if (in_table)
                            begin
                                susp_next[slot_idx] = 1'b0;
                            end
                        end
                        default:
                        begin
                            // unused opcode: no change, zero result
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                cnt_next = CNT_W'(cnt_reg + 1'b1);
                // read of slot cnt issued above, slot cnt-1 updated here
                if (cnt_reg != '0 && !susp_reg[proc_idx])
                begin
                    if (cur_cd == '0)
                    begin
                        if (valid_reg[proc_idx])
                        begin
                            mem_we              = 1'b1;
                            mem_wdata.countdown = TIME_W'(rd_data_reg.period - 1'b1);
                            init_next[proc_idx] = 1'b1;
                            mask_next           = mask_reg | fire_bit;
                        end
                    end
                    else
                    begin
                        mem_we              = 1'b1;
                        mem_wdata.countdown = TIME_W'(cur_cd - 1'b1);
                        init_next[proc_idx] = 1'b1;
                    end
                end
                if (walk_last)
                begin
                    res_valid = 1'b1;
                    res_mask  = mask_next;
                end
            end
            ST_HOLD:
            begin
                res_valid  = 1'b1;
                res_status = pend_status_reg;
                res_mask   = pend_mask_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_load = res_valid && out_free;

    // slot memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            susp_reg      <= '0;
            init_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            susp_reg  <= susp_next;
            init_reg  <= init_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        mask_reg <= mask_next;
        if (res_valid)
        begin
            pend_status_reg <= res_status;
            pend_mask_reg   <= res_mask;
        end
        if (out_load)
        begin
            status_reg     <= res_status;
            fired_mask_reg <= res_mask;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign fired_mask = fired_mask_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for periodic_task_tick_scheduler_top
// holds a slot table scoreboard class, an item driver task, stall generator and watchdog
// depends on ptts_pkg and the scheduler rtl
`timescale 1ns / 100ps

module tb_top;

    import ptts_pkg::*;

    // opcodes past resume do nothing in the block
    localparam logic [OPCODE_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_LAST  = 3'd7;

    localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
    localparam int SLOT_FIELD_MAX = (1 << SLOT_FIELD_W) - 1;

    localparam int RANDOM_ITEMS   = 600;
    localparam int CALM_FIRST     = 250;   // no idling on either side in this stretch
    localparam int CALM_LAST      = 400;
    localparam int DRAIN_POINT    = 450;   // sender holds off until all results are back
    localparam int IDLE_PERCENT   = 36;
    // a tick walk plus one parked result in the holding register
    localparam int END_WAIT       = 2 * (NUM_SLOTS + 1) + 4;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic              status;
        logic [MASK_W-1:0] fired_mask;
    } sched_result_t;

    // mirror of the slot table, predicts one result per accepted item
    class sched_scoreboard;
        bit                slot_live      [NUM_SLOTS];
        bit                slot_paused    [NUM_SLOTS];
        logic [TIME_W-1:0] slot_period    [NUM_SLOTS];
        logic [TIME_W-1:0] slot_countdown [NUM_SLOTS];
        sched_result_t     expected_results[$];
        int                errors;

        function new();
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_live[i]      = 1'b0;
                slot_paused[i]    = 1'b0;
                slot_period[i]    = '0;
                slot_countdown[i] = '0;
            end
            errors = 0;
        endfunction

        // one walk over the table, returns the fired slots
        function logic [MASK_W-1:0] walk_tick();
            logic [MASK_W-1:0] fired;
            fired = '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (!slot_paused[i])
                begin
                    if (slot_countdown[i] == '0)
                    begin
                        if (slot_live[i])
                        begin
                            slot_countdown[i] = slot_period[i] - 1'b1;
                            if (i < MASK_W)
                                fired[i] = 1'b1;
                        end
                    end
                    else
                    begin
                        // decrements even on a deleted slot
                        slot_countdown[i] = slot_countdown[i] - 1'b1;
                    end
                end
            end
            return fired;
        endfunction

        function void note_item(logic [OPCODE_W-1:0] op, logic [SLOT_FIELD_W-1:0] s,
                                logic [TIME_W-1:0] per, logic [TIME_W-1:0] fd);
            sched_result_t r;
            bit            in_table;
            r        = '0;
            in_table = (s < NUM_SLOTS);
            if (op == OP_TICK)
                r.fired_mask = walk_tick();
            else if (op == OP_CREATE)
            begin
                if (!in_table || slot_live[s])
                    r.status = 1'b1;
                else
                begin
                    slot_period[s]    = per;
                    slot_countdown[s] = fd;
                    slot_paused[s]    = 1'b0;
                    slot_live[s]      = 1'b1;
                end
            end
            else if (in_table)
            begin
                if (op == OP_DELETE)
                    slot_live[s] = 1'b0;
                else if (op == OP_SUSPEND)
                    slot_paused[s] = 1'b1;
                else if (op == OP_RESUME)
                    slot_paused[s] = 1'b0;
            end
            expected_results.push_back(r);
        endfunction

        function void check_result(logic st, logic [MASK_W-1:0] mask);
            sched_result_t want;
            if (expected_results.size() == 0)
            begin
                $error("result with nothing expected: status %0d fired_mask %0h", st, mask);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (st !== want.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", want.status, st);
                errors++;
            end
            if (mask !== want.fired_mask)
            begin
                $error("fired_mask mismatch: expected %0h, actual %0h", want.fired_mask, mask);
                errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [OPCODE_W-1:0]     opcode;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [TIME_W-1:0]       period;
    logic [TIME_W-1:0]       first_delay;
    logic                    out_valid;
    logic                    out_stall;
    logic                    status;
    logic [MASK_W-1:0]       fired_mask;

    sched_scoreboard board;
    bit              calm;
    int              quiet_cycles;

    periodic_task_tick_scheduler_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .slot        (slot),
        .period      (period),
        .first_delay (first_delay),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .fired_mask  (fired_mask)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver side: random stall, changed on the falling edge
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= (!calm && ($urandom_range(0, 99) < IDLE_PERCENT));
        end
    end

    // result checker and watchdog on accepted items of either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_result(status, fired_mask);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[periodic_task_tick_scheduler_top] ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // present one item, with random idle cycles first, and hold it until taken
    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [SLOT_FIELD_W-1:0] s,
                             input logic [TIME_W-1:0] per, input logic [TIME_W-1:0] fd);
        @(negedge clk);
        while (!calm && ($urandom_range(0, 99) < IDLE_PERCENT))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        slot        <= s;
        period      <= per;
        first_delay <= fd;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        board.note_item(op, s, per, fd);
    endtask

    initial
    begin
        logic [OPCODE_W-1:0]     op;
        logic [SLOT_FIELD_W-1:0] s;
        logic [TIME_W-1:0]       per;
        logic [TIME_W-1:0]       fd;
        int                      pick;

        board        = new();
        calm         = 1'b0;
        quiet_cycles = 0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = OP_TICK;
        slot         = '0;
        period       = '0;
        first_delay  = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part
        send_item(OP_TICK,    3'd0, '0, '0);              // empty table fires nothing
        send_item(OP_CREATE,  3'd0, '0, '0);              // zero period, zero delay
        send_item(OP_CREATE,  3'd0, 16'd5, 16'd5);        // slot taken, refused
        send_item(OP_TICK,    3'd0, '0, '0);              // fires, reload wraps to max
        send_item(OP_TICK,    3'd0, TIME_MAX, TIME_MAX);
        send_item(OP_CREATE,  3'd7, TIME_MAX, TIME_MAX);  // top slot, largest times
        send_item(OP_CREATE,  3'd1, 16'd1, '0);           // period one fires every tick
        send_item(OP_TICK,    3'd0, '0, '0);
        send_item(OP_TICK,    3'd0, '0, '0);
        send_item(OP_SUSPEND, 3'd1, '0, '0);
        send_item(OP_TICK,    3'd0, '0, '0);              // suspended slot skipped
        send_item(OP_RESUME,  3'd1, '0, '0);
        send_item(OP_TICK,    3'd0, '0, '0);
        send_item(OP_DELETE,  3'd0, '0, '0);              // deleted slot keeps counting down
        send_item(OP_TICK,    3'd0, '0, '0);
        send_item(OP_DELETE,  3'd1, '0, '0);
        send_item(OP_CREATE,  3'd1, 16'd2, 16'd3);
        send_item(OP_CREATE,  3'd3, 16'h8000, 16'h0001);
        send_item(OP_TICK,    3'd0, TIME_MAX, TIME_MAX);
        send_item(OP_UNUSED_FIRST,     3'd3, TIME_MAX, TIME_MAX);
        send_item(OPCODE_W'(OP_UNUSED_FIRST + 1), 3'd5, 16'h5555, 16'haaaa);
        send_item(OP_UNUSED_LAST,      3'd7, 16'haaaa, 16'h5555);
        send_item(OP_SUSPEND, 3'd7, '0, '0);
        send_item(OP_DELETE,  3'd7, '0, '0);              // delete while suspended
        send_item(OP_RESUME,  3'd7, '0, '0);

        // random part: mostly ticks over small periods so slots fire often
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == CALM_FIRST)
                calm = 1'b1;
            if (n == CALM_LAST)
                calm = 1'b0;
            if (n == DRAIN_POINT)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                while (board.pending() != 0)
                    @(negedge clk);
            end
            pick = $urandom_range(0, 99);
            s    = SLOT_FIELD_W'($urandom_range(0, SLOT_FIELD_MAX));
            per  = TIME_W'($urandom);
            fd   = TIME_W'($urandom);
            if (pick < 55)
                op = OP_TICK;
            else if (pick < 72)
            begin
                op = OP_CREATE;
                if ($urandom_range(0, 99) < 85)
                begin
                    per = TIME_W'($urandom_range(0, 6));
                    fd  = TIME_W'($urandom_range(0, 6));
                end
            end
            else if (pick < 80)
                op = OP_DELETE;
            else if (pick < 88)
                op = OP_SUSPEND;
            else if (pick < 95)
                op = OP_RESUME;
            else
                op = OPCODE_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
            send_item(op, s, per, fd);
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // drain, then allow one more walk for anything stray
        while (board.pending() != 0)
            @(posedge clk);
        repeat (END_WAIT) @(posedge clk);

        if (board.errors == 0)
            $display("[periodic_task_tick_scheduler_top] OK");
        else
            $display("[periodic_task_tick_scheduler_top] ERROR");
        $finish;
    end

endmodule

// ===== periodic_task_tick_scheduler_top.f =====
rtl/ptts_pkg.sv
rtl/periodic_task_tick_scheduler_top.sv
tb/sv/tb_top.sv
